@@ design/esst_pkg.sv @@
// Shared constants, types and command codes of the exponentiality spacing statistic block.
// Depends on nothing; every other file of the block but esst_ram uses it.
package esst_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_W    = 32;
  localparam int STAT_W      = 48;
  localparam int COUNT_OUT_W = 11;
  localparam int IDX_W       = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int LOG_W       = SAMPLE_W + CNT_W;
  localparam int SH_W        = $clog2(LOG_W);
  localparam int EXP_W       = $clog2(LOG_W) + 2;
  localparam int LN_W        = $clog2(LOG_W) + 33;
  localparam int Z_W         = LN_W + CNT_W;
  localparam int A_W         = LN_W + CNT_W + 3;
  localparam int UA_W        = A_W - 1;
  localparam int MUL_W       = $clog2(12 * MAX_SAMPLES + 1);
  localparam int DEN_W       = $clog2(7 * MAX_SAMPLES + 2);
  localparam int PROD_W      = UA_W + MUL_W;
  localparam int ITER_W      = $clog2(PROD_W);
  localparam int Q_W         = PROD_W - 16;
  localparam int EXT_W       = (Q_W > STAT_W) ? Q_W : STAT_W + 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [STAT_W-1:0] STAT_SAT = {STAT_W{1'b1}};

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_RD,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_FIN_INIT,
    OP_SP_RD,
    OP_SP_DIFF,
    OP_SP_MUL,
    OP_SP_ACC,
    OP_SP_Z,
    OP_SP_NEXT,
    OP_LOG_Y,
    OP_SAVE_LY,
    OP_LOG_N,
    OP_CALC_A,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic cnt_zero;
    logic pos_zero;
    logic rd_gt;
    logic last;
    logic i_last;
    logic d_zero;
    logic zero_seen;
    logic log_done;
    logic a_pos;
    logic iter_done;
    logic out_busy;
  } status_t;

endpackage

@@ design/esst_chan_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on esst_pkg for the field widths.
interface esst_in_if;
  logic                          valid;
  logic                          ready;
  logic [esst_pkg::SAMPLE_W-1:0] sample;
  logic                          is_sample;
  logic                          last;
  modport source(output valid, sample, is_sample, last, input ready);
  modport sink(input valid, sample, is_sample, last, output ready);
endinterface

interface esst_out_if;
  logic                             valid;
  logic                             ready;
  logic [esst_pkg::STAT_W-1:0]      statistic;
  logic [esst_pkg::COUNT_OUT_W-1:0] sample_count;
  logic                             zero_spacing;
  modport source(output valid, statistic, sample_count, zero_spacing, input ready);
  modport sink(input valid, statistic, sample_count, zero_spacing, output ready);
endinterface

@@ design/exponentiality_spacing_statistic_top.sv @@
// Epstein exponentiality statistic over sorted Q16.16 samples. A sample is inserted by shifting the
// k stored samples greater than it up one RAM entry each, one at a time through the single read
// port, and needs no last compare read when it lands at the front of the store. The last item
// adds a spacing pass, bound by the bit-serial log unit, then two logs, 14 multiply and 66
// divide steps before the result.
// One data set at a time. Reset (rst_ni low, asynchronous) empties the store and the channels;
// store contents are not cleared and are only read after being written.
module exponentiality_spacing_statistic_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  esst_in_if.sink    in_i,
  esst_out_if.source out_o
);

  // Commands flow from the controller to the datapath; status flows back.
  esst_pkg::cmd_t    cmd;
  esst_pkg::status_t status;

  // The controller owns the input handshake: it takes an item only when idle.
  esst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_is_sample_i(in_i.is_sample),
    .in_last_i     (in_i.last),
    .in_ready_o    (in_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // The datapath holds the output register, so a finished result can wait
  // for the sink while the next data set is already loading.
  esst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_sample_i    (in_i.sample),
    .in_last_i      (in_i.last),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_statistic_o(out_o.statistic),
    .out_count_o    (out_o.sample_count),
    .out_zero_o     (out_o.zero_spacing)
  );

endmodule

@@ design/esst_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module esst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/esst_log.sv @@
// Iterative natural log unit: ln(x / 2^16) in signed Q.32 for x > 0.
// Normalizes one bit a cycle, then squares the mantissa once per fraction bit.
// Depends on esst_pkg.
module esst_log (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [esst_pkg::LOG_W-1:0]        x_i,
  output logic                              done_o,
  output logic signed [esst_pkg::LN_W-1:0]  res_o
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_MULF = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [esst_pkg::LOG_W-1:0]     xn_q, xn_d;
  logic [esst_pkg::SH_W-1:0]      sh_q, sh_d;
  logic [31:0]                    m_q, m_d;
  logic [31:0]                    frac_q, frac_d;
  logic [4:0]                     k_q, k_d;
  logic [31:0]                    fl_q, fl_d;
  logic signed [esst_pkg::LN_W-1:0] res_q, res_d;
  logic                           done_q, done_d;

  logic [63:0]                    sq;
  logic [32:0]                    sq_t;
  logic [63:0]                    fprod;
  logic signed [esst_pkg::EXP_W-1:0] es;
  logic signed [esst_pkg::LN_W-1:0]  el;
  localparam logic signed [esst_pkg::LN_W-1:0] LN2_S = esst_pkg::LN_W'(esst_pkg::LN2_Q32);

  assign sq    = m_q * m_q;
  assign sq_t  = sq[63:31];
  assign fprod = frac_q * esst_pkg::LN2_Q32;
  assign es    = esst_pkg::EXP_W'(esst_pkg::LOG_W - 1) - esst_pkg::EXP_W'(sh_q)
               - esst_pkg::EXP_W'(16);
  assign el    = esst_pkg::LN_W'(es);

  always_comb begin
    state_d = state_q;
    xn_d    = xn_q;
    sh_d    = sh_q;
    m_d     = m_q;
    frac_d  = frac_q;
    k_d     = k_q;
    fl_d    = fl_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          xn_d    = x_i;
          sh_d    = '0;
          state_d = L_NORM;
        end
      end
      L_NORM: begin
        if (xn_q[esst_pkg::LOG_W-1]) begin
          m_d     = xn_q[esst_pkg::LOG_W-1 -: 32];
          frac_d  = '0;
          k_d     = '0;
          state_d = L_SQ;
        end else begin
          xn_d = {xn_q[esst_pkg::LOG_W-2:0], 1'b0};
          sh_d = sh_q + 1'b1;
        end
      end
      L_SQ: begin
        frac_d = {frac_q[30:0], sq_t[32]};
        m_d    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        k_d    = k_q + 1'b1;
        if (k_q == 5'd31) begin
          state_d = L_MULF;
        end
      end
      L_MULF: begin
        fl_d    = fprod[63:32];
        state_d = L_FIN;
      end
      L_FIN: begin
        res_d   = el * LN2_S + esst_pkg::LN_W'(fl_q);
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xn_q   <= xn_d;
    sh_q   <= sh_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    k_q    <= k_d;
    fl_q   <= fl_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ design/esst_ctrl.sv @@
// Controller state machine: sequences insertion, spacing pass, logs, multiply and divide.
// Depends on esst_pkg; drives the datapath by command codes only.
module esst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_is_sample_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  esst_pkg::status_t status_i,
  output esst_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INS_CHK  = 5'd1;
  localparam logic [4:0] S_INS_WAIT = 5'd2;
  localparam logic [4:0] S_FIN      = 5'd3;
  localparam logic [4:0] S_SP_RD    = 5'd4;
  localparam logic [4:0] S_SP_WAIT  = 5'd5;
  localparam logic [4:0] S_SP_MUL   = 5'd6;
  localparam logic [4:0] S_SP_ACC   = 5'd7;
  localparam logic [4:0] S_SP_LOG   = 5'd8;
  localparam logic [4:0] S_SP_NEXT  = 5'd9;
  localparam logic [4:0] S_LY       = 5'd10;
  localparam logic [4:0] S_LY_WAIT  = 5'd11;
  localparam logic [4:0] S_LN       = 5'd12;
  localparam logic [4:0] S_LN_WAIT  = 5'd13;
  localparam logic [4:0] S_A_CHK    = 5'd14;
  localparam logic [4:0] S_MUL      = 5'd15;
  localparam logic [4:0] S_DIV_INIT = 5'd16;
  localparam logic [4:0] S_DIV      = 5'd17;
  localparam logic [4:0] S_OUT      = 5'd18;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = esst_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = esst_pkg::OP_LOAD;
          if (in_is_sample_i && !status_i.cnt_full) begin
            state_d = S_INS_CHK;
          end else if (in_last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_INS_CHK: begin
        if (status_i.pos_zero) begin
          cmd_o.op = esst_pkg::OP_INS_PUT;
          state_d  = status_i.last ? S_FIN : S_IDLE;
        end else begin
          cmd_o.op = esst_pkg::OP_INS_RD;
          state_d  = S_INS_WAIT;
        end
      end
      S_INS_WAIT: begin
        if (status_i.rd_gt) begin
          cmd_o.op = esst_pkg::OP_INS_SHIFT;
          state_d  = S_INS_CHK;
        end else begin
          cmd_o.op = esst_pkg::OP_INS_PUT;
          state_d  = status_i.last ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (status_i.cnt_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = esst_pkg::OP_FIN_INIT;
          state_d  = S_SP_RD;
        end
      end
      S_SP_RD: begin
        cmd_o.op = esst_pkg::OP_SP_RD;
        state_d  = S_SP_WAIT;
      end
      S_SP_WAIT: begin
        cmd_o.op = esst_pkg::OP_SP_DIFF;
        state_d  = S_SP_MUL;
      end
      S_SP_MUL: begin
        cmd_o.op = esst_pkg::OP_SP_MUL;
        state_d  = S_SP_ACC;
      end
      S_SP_ACC: begin
        cmd_o.op = esst_pkg::OP_SP_ACC;
        state_d  = status_i.d_zero ? S_SP_NEXT : S_SP_LOG;
      end
      S_SP_LOG: begin
        if (status_i.log_done) begin
          cmd_o.op = esst_pkg::OP_SP_Z;
          state_d  = S_SP_NEXT;
        end
      end
      S_SP_NEXT: begin
        cmd_o.op = esst_pkg::OP_SP_NEXT;
        if (status_i.i_last) begin
          state_d = status_i.zero_seen ? S_OUT : S_LY;
        end else begin
          state_d = S_SP_RD;
        end
      end
      S_LY: begin
        cmd_o.op = esst_pkg::OP_LOG_Y;
        state_d  = S_LY_WAIT;
      end
      S_LY_WAIT: begin
        if (status_i.log_done) begin
          cmd_o.op = esst_pkg::OP_SAVE_LY;
          state_d  = S_LN;
        end
      end
      S_LN: begin
        cmd_o.op = esst_pkg::OP_LOG_N;
        state_d  = S_LN_WAIT;
      end
      S_LN_WAIT: begin
        if (status_i.log_done) begin
          cmd_o.op = esst_pkg::OP_CALC_A;
          state_d  = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (status_i.a_pos) begin
          cmd_o.op = esst_pkg::OP_MUL_INIT;
          state_d  = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        cmd_o.op = esst_pkg::OP_MUL_STEP;
        if (status_i.iter_done) begin
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op = esst_pkg::OP_DIV_INIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = esst_pkg::OP_DIV_STEP;
        if (status_i.iter_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = esst_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/esst_dp.sv @@
// Datapath: sample store, spacing accumulators, log unit, shift-add multiply,
// restoring divide and the output register. Depends on esst_pkg, esst_ram, esst_log.
module esst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  esst_pkg::cmd_t                      cmd_i,
  output esst_pkg::status_t                   status_o,
  input  logic [esst_pkg::SAMPLE_W-1:0]       in_sample_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [esst_pkg::STAT_W-1:0]         out_statistic_o,
  output logic [esst_pkg::COUNT_OUT_W-1:0]    out_count_o,
  output logic                                out_zero_o
);

  esst_pkg::op_e op;
  assign op = cmd_i.op;

  logic [esst_pkg::CNT_W-1:0]    count_q;
  logic [esst_pkg::IDX_W-1:0]    pos_q;
  logic [esst_pkg::IDX_W-1:0]    idx_q;
  logic [esst_pkg::SAMPLE_W-1:0] sample_q;
  logic                          last_q;
  logic [esst_pkg::SAMPLE_W-1:0] prev_q;
  logic [esst_pkg::SAMPLE_W-1:0] diff_q;
  logic [esst_pkg::LOG_W-1:0]    d_q;
  logic [esst_pkg::LOG_W-1:0]    y_q;
  logic signed [esst_pkg::Z_W-1:0]  z_q;
  logic signed [esst_pkg::LN_W-1:0] ly_q;
  logic                          zero_q;
  logic signed [esst_pkg::A_W-1:0]  a_q;
  logic [esst_pkg::PROD_W-1:0]   mcand_q;
  logic [esst_pkg::MUL_W-1:0]    mplier_q;
  logic [esst_pkg::PROD_W-1:0]   prod_q;
  logic [esst_pkg::DEN_W-1:0]    rem_q;
  logic [esst_pkg::ITER_W-1:0]   iter_q;
  logic                          out_valid_q;
  logic [esst_pkg::STAT_W-1:0]   out_stat_q;
  logic [esst_pkg::COUNT_OUT_W-1:0] out_cnt_q;
  logic                          out_zero_q;

  // Sample store.
  logic                          ram_we;
  logic [esst_pkg::IDX_W-1:0]    ram_raddr;
  logic [esst_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [esst_pkg::SAMPLE_W-1:0] ram_rdata;

  assign ram_we    = (op == esst_pkg::OP_INS_SHIFT) || (op == esst_pkg::OP_INS_PUT);
  assign ram_wdata = (op == esst_pkg::OP_INS_SHIFT) ? ram_rdata : sample_q;
  assign ram_raddr = (op == esst_pkg::OP_SP_RD) ? idx_q : pos_q - 1'b1;

  esst_ram #(
    .WIDTH(esst_pkg::SAMPLE_W),
    .DEPTH(esst_pkg::MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Log unit, shared by the spacings, y and n.
  logic                             log_start;
  logic [esst_pkg::LOG_W-1:0]       log_x;
  logic                             log_done;
  logic signed [esst_pkg::LN_W-1:0] log_res;

  assign log_start = ((op == esst_pkg::OP_SP_ACC) && (d_q != '0)) ||
                     (op == esst_pkg::OP_LOG_Y) || (op == esst_pkg::OP_LOG_N);

  always_comb begin
    case (op)
      esst_pkg::OP_LOG_Y: log_x = y_q;
      esst_pkg::OP_LOG_N: log_x = esst_pkg::LOG_W'(count_q) << 16;
      default:            log_x = d_q;
    endcase
  end

  esst_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(log_start),
    .x_i    (log_x),
    .done_o (log_done),
    .res_o  (log_res)
  );

  // Combinational helpers.
  logic [esst_pkg::CNT_W-1:0]        weight;
  logic signed [esst_pkg::LN_W:0]    ldiff;
  logic signed [esst_pkg::A_W-1:0]   a_d;
  logic [esst_pkg::MUL_W-1:0]        mul_k;
  logic [esst_pkg::DEN_W-1:0]        den;
  logic [esst_pkg::DEN_W:0]          r2;
  logic                              ge;
  logic [esst_pkg::EXT_W-1:0]        qx;
  logic [esst_pkg::STAT_W-1:0]       stat_val;

  assign weight = count_q - esst_pkg::CNT_W'(idx_q);
  assign ldiff  = (esst_pkg::LN_W+1)'(ly_q) - (esst_pkg::LN_W+1)'(log_res);
  assign a_d    = ldiff * $signed({1'b0, count_q}) - esst_pkg::A_W'(z_q);
  assign mul_k  = esst_pkg::MUL_W'(count_q * 12);
  assign den    = esst_pkg::DEN_W'(count_q * 7 + 1);
  assign r2     = {rem_q, prod_q[esst_pkg::PROD_W-1]};
  assign ge     = (r2 >= {1'b0, den});
  assign qx     = esst_pkg::EXT_W'(prod_q >> 16);

  always_comb begin
    if (count_q == '0) begin
      stat_val = '0;
    end else if (zero_q) begin
      stat_val = esst_pkg::STAT_SAT;
    end else if (a_q[esst_pkg::A_W-1] || (a_q == '0)) begin
      stat_val = '0;
    end else if (qx > esst_pkg::EXT_W'(esst_pkg::STAT_SAT)) begin
      stat_val = esst_pkg::STAT_SAT;
    end else begin
      stat_val = qx[esst_pkg::STAT_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == esst_pkg::OP_INS_PUT) begin
        count_q <= count_q + 1'b1;
      end else if (op == esst_pkg::OP_EMIT) begin
        count_q <= '0;
      end
      if (op == esst_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (op)
      esst_pkg::OP_LOAD: begin
        sample_q <= in_sample_i;
        last_q   <= in_last_i;
        pos_q    <= count_q[esst_pkg::IDX_W-1:0];
      end
      esst_pkg::OP_INS_SHIFT: begin
        pos_q <= pos_q - 1'b1;
      end
      esst_pkg::OP_FIN_INIT: begin
        idx_q  <= '0;
        prev_q <= '0;
        y_q    <= '0;
        z_q    <= '0;
        zero_q <= 1'b0;
      end
      esst_pkg::OP_SP_DIFF: begin
        diff_q <= ram_rdata - prev_q;
        prev_q <= ram_rdata;
      end
      esst_pkg::OP_SP_MUL: begin
        d_q <= weight * diff_q;
      end
      esst_pkg::OP_SP_ACC: begin
        y_q <= y_q + d_q;
        if (d_q == '0) begin
          zero_q <= 1'b1;
        end
      end
      esst_pkg::OP_SP_Z: begin
        z_q <= z_q + esst_pkg::Z_W'(log_res);
      end
      esst_pkg::OP_SP_NEXT: begin
        idx_q <= idx_q + 1'b1;
      end
      esst_pkg::OP_SAVE_LY: begin
        ly_q <= log_res;
      end
      esst_pkg::OP_CALC_A: begin
        a_q <= a_d;
      end
      esst_pkg::OP_MUL_INIT: begin
        mcand_q  <= esst_pkg::PROD_W'(a_q[esst_pkg::UA_W-1:0]);
        mplier_q <= mul_k;
        prod_q   <= '0;
        iter_q   <= '0;
      end
      esst_pkg::OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q  <= {mcand_q[esst_pkg::PROD_W-2:0], 1'b0};
        mplier_q <= mplier_q >> 1;
        iter_q   <= iter_q + 1'b1;
      end
      esst_pkg::OP_DIV_INIT: begin
        rem_q  <= '0;
        iter_q <= '0;
      end
      esst_pkg::OP_DIV_STEP: begin
        rem_q  <= ge ? esst_pkg::DEN_W'(r2 - {1'b0, den}) : r2[esst_pkg::DEN_W-1:0];
        prod_q <= {prod_q[esst_pkg::PROD_W-2:0], ge};
        iter_q <= iter_q + 1'b1;
      end
      esst_pkg::OP_EMIT: begin
        out_stat_q <= stat_val;
        out_cnt_q  <= esst_pkg::COUNT_OUT_W'(count_q);
        out_zero_q <= (count_q != '0) && zero_q;
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  always_comb begin
    status_o.cnt_full  = (count_q == esst_pkg::CNT_W'(esst_pkg::MAX_SAMPLES));
    status_o.cnt_zero  = (count_q == '0);
    status_o.pos_zero  = (pos_q == '0);
    status_o.rd_gt     = (ram_rdata > sample_q);
    status_o.last      = last_q;
    status_o.i_last    = (esst_pkg::CNT_W'(idx_q) + 1'b1 == count_q);
    status_o.d_zero    = (d_q == '0);
    status_o.zero_seen = zero_q;
    status_o.log_done  = log_done;
    status_o.a_pos     = !a_q[esst_pkg::A_W-1] && (a_q != '0);
    status_o.iter_done = (op == esst_pkg::OP_MUL_STEP) ?
                         (iter_q == esst_pkg::ITER_W'(esst_pkg::MUL_W - 1)) :
                         (iter_q == esst_pkg::ITER_W'(esst_pkg::PROD_W - 1));
    status_o.out_busy  = out_valid_q;
  end

  assign out_valid_o     = out_valid_q;
  assign out_statistic_o = out_stat_q;
  assign out_count_o     = out_cnt_q;
  assign out_zero_o      = out_zero_q;

endmodule
